>>> src/vtpd_pkg.sv
`default_nettype none
package vtpd_pkg;

    // signed 32 x 32 products plus four-term sum
    localparam int SUM_W    = 66;
    // quotient bits kept; anything at or above 2^QBITS is flagged as overflow
    localparam int QBITS    = 33;
    // divider: one overflow-check stage, then one stage per quotient bit
    localparam int DIV_LAT  = QBITS + 1;
    localparam int NUM_REGS = 8;
    localparam int IDX_W    = 3;
    localparam int LANES    = 3;

    // per-beat sideband that rides alongside the divider lanes
    typedef struct packed {
        logic             valid;
        logic             wz;
        logic [LANES-1:0] neg;
    } vtpd_side_t;

endpackage
`default_nettype wire

>>> src/vtpd_div.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
// Assumes den != 0; flags quotient >= 2^QBITS as overflow.
module vtpd_div #(
    parameter int NW = 82,
    parameter int DW = 66
) (
    input  wire logic                       clk,
    input  wire logic [NW-1:0]              num,
    input  wire logic [DW-1:0]              den,
    output logic      [vtpd_pkg::QBITS-1:0] quo,
    output logic                            ovf
);

    localparam int QB = vtpd_pkg::QBITS;
    localparam int CW = (NW > DW + QB) ? NW : DW + QB;

    logic [DW-1:0] rem_reg [QB+1];
    logic [DW-1:0] den_reg [QB+1];
    logic [QB-1:0] lo_reg  [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    logic          ovf_reg [QB+1];

    logic [CW-1:0] num_ext;
    logic [CW-1:0] den_sh;

    assign num_ext = CW'(num);
    assign den_sh  = CW'(den) << QB;

    // stage 0: overflow check, seed the partial remainder with the top bits
    always_ff @(posedge clk)
    begin
        ovf_reg[0] <= (num_ext >= den_sh);
        rem_reg[0] <= DW'(num >> QB);
        lo_reg[0]  <= num[QB-1:0];
        den_reg[0] <= den;
        q_reg[0]   <= '0;
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [DW:0]   r2;
        logic          ge;
        logic [DW:0]   diff;

        assign r2   = {rem_reg[k], lo_reg[k][QB-1]};
        assign ge   = (r2 >= {1'b0, den_reg[k]});
        assign diff = r2 - {1'b0, den_reg[k]};

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= ge ? diff[DW-1:0] : r2[DW-1:0];
            q_reg[k+1]   <= {q_reg[k][QB-2:0], ge};
            lo_reg[k+1]  <= {lo_reg[k][QB-2:0], 1'b0};
            den_reg[k+1] <= den_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
        end
    end

    assign quo = q_reg[QB];
    assign ovf = ovf_reg[QB];

endmodule
`default_nettype wire

>>> src/vertex_transform_perspective_divide_core.sv
`default_nettype none
// Vertex transform and perspective divide.
// Command channel: a vertex (pos_x, pos_y, pos_z, signed fixed point) is taken
// on a rising edge with start high and busy low. busy stays low: the datapath
// is fully pipelined and takes one vertex every cycle.
// Result: done is high for one cycle with dev_x/y/z, w_zero and saturated.
// done follows the accepting edge through these registers: products are
// registered on that edge, then sum and abs/shift stages, a 34-stage restoring
// divider (one overflow check, then one quotient bit per stage), one output stage.
// The divider stage count sets the latency; throughput is one beat a cycle.
// Config: cfg_valid/cfg_ready with cfg_index and 64-bit cfg_data; cfg_ready
// is always high. Write only while no vertex is in flight.
// Reset loads the identity matrix and clears all in-flight beats.
// The receiver cannot stall: results leave on done with no back-pressure.
module vertex_transform_perspective_divide_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic signed [31:0]          pos_x,
    input  wire logic signed [31:0]          pos_y,
    input  wire logic signed [31:0]          pos_z,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [vtpd_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [63:0]                 cfg_data,
    output logic                             done,
    output logic signed [31:0]               dev_x,
    output logic signed [31:0]               dev_y,
    output logic signed [31:0]               dev_z,
    output logic                             w_zero,
    output logic                             saturated
);

    localparam int SW = vtpd_pkg::SUM_W;
    localparam int NW = SW + FRAC_BITS;
    localparam int QB = vtpd_pkg::QBITS;
    localparam int DL = vtpd_pkg::DIV_LAT;
    localparam int NL = vtpd_pkg::LANES;
    localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

    logic        accept;
    logic [63:0] m_reg [vtpd_pkg::NUM_REGS];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg[0] <= ONE;
            m_reg[1] <= '0;
            m_reg[2] <= ONE << 32;
            m_reg[3] <= '0;
            m_reg[4] <= '0;
            m_reg[5] <= ONE;
            m_reg[6] <= '0;
            m_reg[7] <= ONE << 32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            m_reg[cfg_index] <= cfg_data;
        end
    end

    logic signed [31:0] pos_in [3];
    logic signed [31:0] ent [4][4];

    assign pos_in[0] = pos_x;
    assign pos_in[1] = pos_y;
    assign pos_in[2] = pos_z;

    for (genvar r = 0; r < 4; r++)
    begin : g_row
        for (genvar c = 0; c < 4; c++)
        begin : g_col
            assign ent[r][c] = m_reg[r*2 + c/2][(c%2)*32 +: 32];
        end
    end

    // stage 1: products
    logic signed [63:0] prod_next [4][4];
    logic signed [63:0] prod_reg  [4][4];
    logic               v1_reg;

    for (genvar c = 0; c < 4; c++)
    begin : g_prod
        for (genvar r = 0; r < 3; r++)
        begin : g_mul
            assign prod_next[c][r] = pos_in[r] * ent[r][c];
        end
        // implicit w = 1.0 on the translation row
        assign prod_next[c][3] = 64'(ent[3][c]) <<< FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // stage 2: column sums
    logic signed [SW-1:0] sum_reg [4];
    logic                 v2_reg;

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            sum_reg[c] <= SW'(prod_reg[c][0]) + SW'(prod_reg[c][1])
                        + SW'(prod_reg[c][2]) + SW'(prod_reg[c][3]);
        end
    end

    // stage 3: magnitudes, signs, scaled numerators
    logic [NW-1:0] num_reg [NL];
    logic [SW-1:0] den_reg;
    logic [NL-1:0] neg_reg;
    logic          wz_reg;
    logic          v3_reg;

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NL; c++)
        begin
            num_reg[c] <= {(sum_reg[c][SW-1] ? SW'(-sum_reg[c]) : SW'(sum_reg[c])),
                           FRAC_BITS'(0)};
            neg_reg[c] <= sum_reg[c][SW-1] ^ sum_reg[3][SW-1];
        end
        den_reg <= sum_reg[3][SW-1] ? SW'(-sum_reg[3]) : SW'(sum_reg[3]);
        wz_reg  <= (sum_reg[3] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // divider lanes
    logic [QB-1:0] quo [NL];
    logic [NL-1:0] ovf;

    for (genvar l = 0; l < NL; l++)
    begin : g_lane
        vtpd_div #(
            .NW (NW),
            .DW (SW)
        ) u_div (
            .clk (clk),
            .num (num_reg[l]),
            .den (den_reg),
            .quo (quo[l]),
            .ovf (ovf[l])
        );
    end

    vtpd_pkg::vtpd_side_t side_reg [DL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DL; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else
        begin
            side_reg[0] <= '{valid: v3_reg, wz: wz_reg, neg: neg_reg};
            for (int i = 1; i < DL; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // output stage: sign, saturation, zero-w override
    logic [31:0]   res_next [NL];
    logic [NL-1:0] sat_next;

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            if (side_reg[DL-1].neg[l])
            begin
                sat_next[l] = ovf[l] | (quo[l] > QB'(33'h0_8000_0000));
                res_next[l] = sat_next[l] ? 32'h8000_0000 : 32'(~quo[l] + QB'(1));
            end
            else
            begin
                sat_next[l] = ovf[l] | quo[l][QB-1] | quo[l][31];
                res_next[l] = sat_next[l] ? 32'h7FFF_FFFF : quo[l][31:0];
            end
            if (side_reg[DL-1].wz)
            begin
                res_next[l] = '0;
                sat_next[l] = 1'b0;
            end
        end
    end

    logic        done_reg;
    logic [31:0] dev_reg [NL];
    logic        wz_out_reg;
    logic        sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= side_reg[DL-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dev_reg    <= res_next;
        wz_out_reg <= side_reg[DL-1].wz;
        sat_reg    <= |sat_next;
    end

    assign done      = done_reg;
    assign dev_x     = dev_reg[0];
    assign dev_y     = dev_reg[1];
    assign dev_z     = dev_reg[2];
    assign w_zero    = wz_out_reg;
    assign saturated = sat_reg;

endmodule
`default_nettype wire

>>> bench/vertex_transform_perspective_divide_core_tb.sv
module vertex_transform_perspective_divide_core_tb;

    localparam int FRAC       = 16;
    localparam int DRAIN_WAIT = 45;
    localparam int MAX_CYCLES = 200000;

    typedef enum logic [2:0] {
        M_ROW0_COLS01, M_ROW0_COLS23, M_ROW1_COLS01, M_ROW1_COLS23,
        M_ROW2_COLS01, M_ROW2_COLS23, M_ROW3_COLS01, M_ROW3_COLS23
    } matrix_reg_e;

    typedef struct {
        logic [31:0] dev_x;
        logic [31:0] dev_y;
        logic [31:0] dev_z;
        logic        w_zero;
        logic        saturated;
    } device_coord_t;

    class vertex_scoreboard;
        logic [63:0]   mat[8];
        device_coord_t pending_q[$];
        int            errors;

        function new();
            reset_matrix();
            errors = 0;
        endfunction

        function void reset_matrix();
            foreach (mat[i]) mat[i] = '0;
            mat[M_ROW0_COLS01] = 64'(1) << FRAC;
            mat[M_ROW1_COLS01] = 64'(1) << (FRAC + 32);
            mat[M_ROW2_COLS23] = 64'(1) << FRAC;
            mat[M_ROW3_COLS23] = 64'(1) << (FRAC + 32);
        endfunction

        function logic signed [127:0] entry(int row, int col);
            logic [63:0] r;
            logic [31:0] e;
            r = mat[row * 2 + col / 2];
            e = (col % 2) ? r[63:32] : r[31:0];
            return {{96{e[31]}}, e};
        endfunction

        // one quotient, truncated toward zero, clamped to 32 bits
        function logic [31:0] divide_clamp(logic signed [127:0] num,
                                           logic signed [127:0] den, ref logic sat);
            logic         neg;
            logic [127:0] n;
            logic [127:0] d;
            logic [127:0] q;
            neg = num[127] ^ den[127];
            n = num[127] ? -num : num;
            d = den[127] ? -den : den;
            n = n << FRAC;
            q = n / d;
            if (neg) begin
                if (q > 128'h8000_0000) begin
                    sat = 1'b1;
                    return 32'h8000_0000;
                end
                return -q[31:0];
            end
            if (q > 128'h7FFF_FFFF) begin
                sat = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return q[31:0];
        endfunction

        function void note_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
            logic signed [127:0] v[4];
            logic signed [127:0] s[4];
            device_coord_t       res;
            logic                sat;
            v[0] = {{96{x[31]}}, x};
            v[1] = {{96{y[31]}}, y};
            v[2] = {{96{z[31]}}, z};
            v[3] = 128'(1) << FRAC;
            for (int c = 0; c < 4; c++) begin
                s[c] = '0;
                for (int r = 0; r < 4; r++)
                    s[c] = s[c] + v[r] * entry(r, c);
            end
            sat = 1'b0;
            if (s[3] == 0) begin
                res = '{32'd0, 32'd0, 32'd0, 1'b1, 1'b0};
            end
            else begin
                res.dev_x  = divide_clamp(s[0], s[3], sat);
                res.dev_y  = divide_clamp(s[1], s[3], sat);
                res.dev_z  = divide_clamp(s[2], s[3], sat);
                res.w_zero = 1'b0;
                res.saturated = sat;
            end
            pending_q.push_back(res);
        endfunction

        function void check_result(device_coord_t got);
            device_coord_t exp_r;
            if (pending_q.size() == 0) begin
                $error("result beat with nothing outstanding");
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.dev_x !== exp_r.dev_x) begin
                $error("dev_x expected %h got %h", exp_r.dev_x, got.dev_x);
                errors++;
            end
            if (got.dev_y !== exp_r.dev_y) begin
                $error("dev_y expected %h got %h", exp_r.dev_y, got.dev_y);
                errors++;
            end
            if (got.dev_z !== exp_r.dev_z) begin
                $error("dev_z expected %h got %h", exp_r.dev_z, got.dev_z);
                errors++;
            end
            if (got.w_zero !== exp_r.w_zero) begin
                $error("w_zero expected %b got %b", exp_r.w_zero, got.w_zero);
                errors++;
            end
            if (got.saturated !== exp_r.saturated) begin
                $error("saturated expected %b got %b", exp_r.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [31:0] pos_z = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [63:0]        cfg_data = '0;
    logic               done;
    logic signed [31:0] dev_x;
    logic signed [31:0] dev_y;
    logic signed [31:0] dev_z;
    logic               w_zero;
    logic               saturated;

    vertex_scoreboard sb = new();
    int               cycle_count = 0;
    logic [63:0]      next_mat[8];

    vertex_transform_perspective_divide_core #(.FRAC_BITS(FRAC)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .dev_x(dev_x), .dev_y(dev_y), .dev_z(dev_z),
        .w_zero(w_zero), .saturated(saturated)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("vertex_transform_perspective_divide_core regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        device_coord_t got;
        if (rst_n && done) begin
            got = '{dev_x, dev_y, dev_z, w_zero, saturated};
            sb.check_result(got);
        end
    end

    // start stays high across back-to-back beats; only idle_gap lowers it
    task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        @(negedge clk);
        start <= 1'b1;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_vertex(x, y, z);
    endtask

    task automatic idle_gap(int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic settle();
        idle_gap(1);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(matrix_reg_e idx, logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.mat[idx] = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_matrix();
        for (int i = 0; i < 8; i++)
            write_reg(matrix_reg_e'(i), next_mat[i]);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 6))
            0: return $urandom();
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'd0;
            default: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
        endcase
    endfunction

    task automatic run_random(int n, bit idling);
        for (int i = 0; i < n; i++) begin
            if (idling && $urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 14));
            send_vertex(rand_word(), rand_word(), rand_word());
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // identity after reset
        send_vertex(32'd0, 32'd0, 32'd0);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vertex(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
        send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
        settle();

        // w' = z: zero w, saturation both ways, negative w
        foreach (next_mat[i]) next_mat[i] = '0;
        next_mat[M_ROW0_COLS01] = 64'h0000_0000_0001_0000;
        next_mat[M_ROW1_COLS01] = 64'h0001_0000_0000_0000;
        next_mat[M_ROW2_COLS23] = 64'h0001_0000_0001_0000;
        load_matrix();
        send_vertex(32'h0002_0000, 32'h0003_0000, 32'd0);
        send_vertex(32'h0002_0000, 32'hFFFD_0000, 32'h0001_0000);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_vertex(32'h0005_0000, 32'd0, 32'hFFFE_0000);
        send_vertex(32'h8000_0000, 32'd0, 32'h8000_0000);
        send_vertex(32'd0, 32'd1, 32'h7FFF_FFFF);
        settle();

        // matrix extremes
        foreach (next_mat[i]) next_mat[i] = 64'h8000_0000_8000_0000;
        load_matrix();
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        settle();
        foreach (next_mat[i]) next_mat[i] = 64'hFFFF_FFFF_FFFF_FFFF;
        load_matrix();
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        settle();
        foreach (next_mat[i]) next_mat[i] = 64'h7FFF_FFFF_7FFF_FFFF;
        load_matrix();
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vertex(32'h8000_0000, 32'h0001_0000, 32'd0);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            foreach (next_mat[i])
                next_mat[i] = (ph % 2) ? {$urandom(), $urandom()}
                                       : {rand_word(), rand_word()};
            // keep some phases well-conditioned: w' mostly the translation term
            if (ph % 3 == 0)
                next_mat[M_ROW3_COLS23][63:32] = 32'($urandom_range(1, 1 << 18));
            load_matrix();
            run_random(24, ph != 7);
            if (ph == 3) begin
                // sender holds off until the pipe is empty
                idle_gap(1);
                while (sb.pending_q.size() != 0) @(posedge clk);
            end
            run_random(24, ph != 7);
            settle();
        end

        if (sb.errors == 0)
            $display("vertex_transform_perspective_divide_core regression: pass");
        else
            $display("vertex_transform_perspective_divide_core regression: fail");
        $finish;
    end

endmodule
